// File: rtl/sqv_pkg.sv
// Shared types, codes and constants of the sprite quad vertex setup block.
package sqv_pkg;

    localparam int MAX_QUADS_DEF     = 512;
    localparam int TEXTURE_SLOTS_DEF = 32;
    localparam int ANGLE_BITS_DEF    = 12;

    // Scan index carried between controller and datapath (slots up to 127).
    localparam int IDX_W = 7;

    localparam logic [1:0] CMD_BEGIN    = 2'd0;
    localparam logic [1:0] CMD_PLAIN    = 2'd1;
    localparam logic [1:0] CMD_TEXTURED = 2'd2;
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BATCH_FULL = 2'd1;
    localparam logic [1:0] ST_SLOTS_FULL = 2'd2;

    // Sine polynomial coefficients, Q30.
    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598668;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172270;

    // Last polynomial step: round and store.
    localparam logic [2:0] POLY_LAST = 3'd6;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic [11:0]        angle;
        logic               flip_x;
        logic [15:0]        texture_id;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic               tex_u;
        logic               tex_v;
        logic [4:0]         slot_index;
        logic [10:0]        vertex_index;
        logic [1:0]         status;
        logic               last_of_quad;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_POLY,
        S_PROD,
        S_VOFF,
        S_VOUT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic             load_item;
        logic             clear_quads;
        logic             inc_quads;
        logic             scan_hit;
        logic             alloc;
        logic [IDX_W-1:0] idx;
        logic             poly_en;
        logic             phase;
        logic [2:0]       step;
        logic             prod_en;
        logic             voff_en;
        logic [1:0]       corner;
        logic             out_load;
        logic             out_err;
        logic [1:0]       err_status;
    } t_dp_cmd;

    typedef struct packed {
        logic quads_full;
        logic slots_full;
        logic scan_done;
        logic id_match;
    } t_dp_status;

    // Coefficient of each polynomial step (zero outside steps 1 to 5); steps 2 to 5 subtract it.
    function automatic logic [30:0] sin_coef(input logic [2:0] step);
        logic [30:0] c;
        c = '0;
        case (step)
            3'd1:    c = SIN_C9;
            3'd2:    c = SIN_C7;
            3'd3:    c = SIN_C5;
            3'd4:    c = SIN_C3;
            3'd5:    c = SIN_C1;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/sqv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sqv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/sqv_ctrl.sv
// Controller state machine of the sprite quad vertex setup block.
module sqv_ctrl #(
    parameter int TEXTURE_SLOTS = sqv_pkg::TEXTURE_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_command,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  sqv_pkg::t_dp_status i_status,
    output sqv_pkg::t_dp_cmd    o_cmd
);
    localparam int SW = $clog2(TEXTURE_SLOTS + 1);

    sqv_pkg::t_state r_state, n_state;
    logic [SW-1:0]   r_idx, n_idx;
    logic [2:0]      r_step, n_step;
    logic            r_phase, n_phase;
    logic [1:0]      r_corner, n_corner;
    logic [1:0]      r_err, n_err;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sqv_pkg::S_IDLE;
            r_idx       <= '0;
            r_step      <= '0;
            r_phase     <= 1'b0;
            r_corner    <= '0;
            r_err       <= sqv_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_step      <= n_step;
            r_phase     <= n_phase;
            r_corner    <= n_corner;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_step   = r_step;
        n_phase  = r_phase;
        n_corner = r_corner;
        n_err    = r_err;
        o_cmd            = '0;
        o_cmd.idx        = sqv_pkg::IDX_W'(r_idx);
        o_cmd.phase      = r_phase;
        o_cmd.step       = r_step;
        o_cmd.corner     = r_corner;
        o_cmd.err_status = r_err;
        case (r_state)
            sqv_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_idx    = '0;
                    n_step   = '0;
                    n_phase  = 1'b0;
                    n_corner = '0;
                    case (i_command)
                        sqv_pkg::CMD_BEGIN: begin
                            o_cmd.clear_quads = 1'b1;
                        end
                        sqv_pkg::CMD_PLAIN, sqv_pkg::CMD_TEXTURED: begin
                            if (i_status.quads_full) begin
                                n_err   = sqv_pkg::ST_BATCH_FULL;
                                n_state = sqv_pkg::S_ERR;
                            end else if (i_command == sqv_pkg::CMD_TEXTURED) begin
                                n_state = sqv_pkg::S_SCAN_RD;
                            end else begin
                                n_state = sqv_pkg::S_POLY;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sqv_pkg::S_SCAN_RD: begin
                if (i_status.scan_done) begin
                    if (i_status.slots_full) begin
                        n_err   = sqv_pkg::ST_SLOTS_FULL;
                        n_state = sqv_pkg::S_ERR;
                    end else begin
                        o_cmd.alloc = 1'b1;
                        n_state     = sqv_pkg::S_POLY;
                    end
                end else begin
                    n_state = sqv_pkg::S_SCAN_CMP;
                end
            end
            sqv_pkg::S_SCAN_CMP: begin
                if (i_status.id_match) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = sqv_pkg::S_POLY;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = sqv_pkg::S_SCAN_RD;
                end
            end
            sqv_pkg::S_POLY: begin
                o_cmd.poly_en = 1'b1;
                if (r_step == sqv_pkg::POLY_LAST) begin
                    n_step = '0;
                    if (r_phase) begin
                        n_phase = 1'b0;
                        n_state = sqv_pkg::S_PROD;
                    end else begin
                        n_phase = 1'b1;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            sqv_pkg::S_PROD: begin
                o_cmd.prod_en = 1'b1;
                if (r_step == 3'd3) begin
                    n_step  = '0;
                    n_state = sqv_pkg::S_VOFF;
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            sqv_pkg::S_VOFF: begin
                o_cmd.voff_en = 1'b1;
                n_state       = sqv_pkg::S_VOUT;
            end
            sqv_pkg::S_VOUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_corner == 2'd3) begin
                        o_cmd.inc_quads = 1'b1;
                        n_corner        = '0;
                        n_state         = sqv_pkg::S_IDLE;
                    end else begin
                        n_corner = r_corner + 2'd1;
                        n_state  = sqv_pkg::S_VOFF;
                    end
                end
            end
            sqv_pkg::S_ERR: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_err  = 1'b1;
                    n_state        = sqv_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sqv_pkg::S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (r_out_valid && i_out_stall);
    end

    assign o_in_stall  = (r_state != sqv_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    a_last_vertex_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sqv_pkg::S_VOUT && out_free && r_corner == 2'd3)
            |=> (r_state == sqv_pkg::S_IDLE))
        else $error("last vertex did not return to idle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.out_load)
        else $error("held output word overwritten");

    a_error_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sqv_pkg::S_ERR)
            |-> (r_err == sqv_pkg::ST_BATCH_FULL || r_err == sqv_pkg::ST_SLOTS_FULL))
        else $error("error result without an error status");
endmodule

// File: rtl/sqv_datapath.sv
// Datapath: slot table, shared multiplier, sine polynomial, vertex arithmetic.
module sqv_datapath #(
    parameter int MAX_QUADS     = sqv_pkg::MAX_QUADS_DEF,
    parameter int TEXTURE_SLOTS = sqv_pkg::TEXTURE_SLOTS_DEF,
    parameter int ANGLE_BITS    = sqv_pkg::ANGLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sqv_pkg::t_in_word    i_in_word,
    input  sqv_pkg::t_dp_cmd     i_cmd,
    output sqv_pkg::t_dp_status  o_status,
    output sqv_pkg::t_out_word   o_out_word
);
    localparam int QW = $clog2(MAX_QUADS + 1);
    localparam int SW = $clog2(TEXTURE_SLOTS + 1);
    localparam int AW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
    localparam int NB = ANGLE_BITS - 2;
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << NB;

    logic signed [31:0]     r_cx, r_cy, r_sx, r_sy;
    logic [ANGLE_BITS-1:0]  r_ang;
    logic                   r_flip;
    logic [15:0]            r_id;
    logic [SW-1:0]          r_slot;
    logic [QW-1:0]          r_qc;
    logic [SW-1:0]          r_used;
    logic signed [65:0]     r_prod;
    logic [30:0]            r_x2;
    logic signed [17:0]     r_sin, r_cos;
    logic signed [48:0]     r_p [4];
    logic signed [32:0]     r_offx, r_offy;
    sqv_pkg::t_out_word     r_out;

    logic [15:0]            rdata;
    logic [ANGLE_BITS-1:0]  ang_eff;
    logic [1:0]             quadrant;
    logic [NB:0]            rem;
    logic [30:0]            x;
    logic [30:0]            prod_hi;
    logic signed [32:0]     t_sub;
    logic signed [32:0]     mul_a, mul_b;
    logic signed [65:0]     mul_p;
    logic [32:0]            v_round;
    logic [16:0]            v_mag;
    logic signed [17:0]     trig_val;
    logic                   cxn, cyn, a_neg;
    logic signed [49:0]     ta, tb, tc, td, sum_x, sum_y;
    logic signed [33:0]     vx, vy;
    logic [12:0]            qc13;

    sqv_ram #(.WIDTH(16), .DEPTH(TEXTURE_SLOTS), .AW(AW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alloc),
        .i_waddr (AW'(r_used)),
        .i_wdata (r_id),
        .i_raddr (AW'(i_cmd.idx)),
        .o_rdata (rdata)
    );

    assign o_status.quads_full = (r_qc >= QW'(MAX_QUADS));
    assign o_status.slots_full = (r_used >= SW'(TEXTURE_SLOTS));
    assign o_status.scan_done  = (i_cmd.idx >= sqv_pkg::IDX_W'(r_used));
    assign o_status.id_match   = (rdata == r_id);

    // Sine argument: cosine is the sine a quarter turn later.
    always_comb begin
        ang_eff  = r_ang + (i_cmd.phase ? QUARTER : '0);
        quadrant = ang_eff[ANGLE_BITS-1 -: 2];
        rem      = {1'b0, ang_eff[NB-1:0]};
        if (quadrant[0]) begin
            rem = (NB+1)'(QUARTER) - rem;
        end
        x = 31'(rem) << (30 - NB);
    end

    assign prod_hi = r_prod[60:30];
    assign t_sub   = $signed({2'b00, sqv_pkg::sin_coef(i_cmd.step)})
                     - $signed({2'b00, prod_hi});

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.prod_en) begin
            case (i_cmd.step[1:0])
                2'd0:    begin mul_a = 33'(r_cos); mul_b = 33'(r_sx); end
                2'd1:    begin mul_a = 33'(r_sin); mul_b = 33'(r_sy); end
                2'd2:    begin mul_a = 33'(r_sin); mul_b = 33'(r_sx); end
                default: begin mul_a = 33'(r_cos); mul_b = 33'(r_sy); end
            endcase
        end else begin
            case (i_cmd.step)
                3'd0:    begin mul_a = $signed({2'b00, x});       mul_b = $signed({2'b00, x}); end
                3'd1:    begin
                    mul_a = $signed({2'b00, prod_hi});
                    mul_b = $signed({2'b00, sqv_pkg::SIN_C9});
                end
                3'd2, 3'd3, 3'd4: begin
                    mul_a = $signed({2'b00, r_x2});
                    mul_b = t_sub;
                end
                default: begin mul_a = $signed({2'b00, x});       mul_b = t_sub; end
            endcase
        end
    end
    assign mul_p = mul_a * mul_b;

    // Round Q30 to Q16 half up, clamp to one, apply the quadrant sign.
    always_comb begin
        v_round  = (33'(r_prod[61:30]) + 33'd8192) >> 14;
        v_mag    = (v_round > 33'd65536) ? 17'd65536 : v_round[16:0];
        trig_val = quadrant[1] ? -$signed({1'b0, v_mag}) : $signed({1'b0, v_mag});
    end

    // Corner signs: x negative on corners 0 and 3, y negative on 0 and 1.
    always_comb begin
        cxn   = (i_cmd.corner == 2'd0) || (i_cmd.corner == 2'd3);
        cyn   = (i_cmd.corner == 2'd0) || (i_cmd.corner == 2'd1);
        a_neg = cxn ^ r_flip;
        ta    = a_neg ? -50'(r_p[0]) : 50'(r_p[0]);
        tb    = cyn   ? -50'(r_p[1]) : 50'(r_p[1]);
        tc    = a_neg ? -50'(r_p[2]) : 50'(r_p[2]);
        td    = cyn   ? -50'(r_p[3]) : 50'(r_p[3]);
        sum_x = ta - tb + 50'sd65536;
        sum_y = tc + td + 50'sd65536;
        vx    = 34'(r_cx) + 34'(r_offx);
        vy    = 34'(r_cy) + 34'(r_offy);
        qc13  = 13'(r_qc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qc   <= '0;
            r_used <= '0;
        end else begin
            if (i_cmd.clear_quads) begin
                r_qc <= '0;
            end else if (i_cmd.inc_quads) begin
                r_qc <= r_qc + 1'b1;
            end
            if (i_cmd.alloc) begin
                r_used <= r_used + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cx   <= i_in_word.center_x;
            r_cy   <= i_in_word.center_y;
            r_sx   <= i_in_word.size_x;
            r_sy   <= i_in_word.size_y;
            r_id   <= i_in_word.texture_id;
            r_slot <= '0;
            if (i_in_word.command == sqv_pkg::CMD_TEXTURED) begin
                r_ang  <= ANGLE_BITS'(i_in_word.angle);
                r_flip <= i_in_word.flip_x;
            end else begin
                r_ang  <= '0;
                r_flip <= 1'b0;
            end
        end
        if (i_cmd.scan_hit) begin
            r_slot <= SW'(i_cmd.idx);
        end
        if (i_cmd.alloc) begin
            r_slot <= r_used;
        end
        if (i_cmd.poly_en) begin
            r_prod <= mul_p;
            if (i_cmd.step == 3'd1) begin
                r_x2 <= prod_hi;
            end
            if (i_cmd.step == sqv_pkg::POLY_LAST) begin
                if (i_cmd.phase) begin
                    r_cos <= trig_val;
                end else begin
                    r_sin <= trig_val;
                end
            end
        end
        if (i_cmd.prod_en) begin
            r_p[i_cmd.step[1:0]] <= 49'(mul_p);
        end
        if (i_cmd.voff_en) begin
            r_offx <= 33'(sum_x >>> 17);
            r_offy <= 33'(sum_y >>> 17);
        end
        if (i_cmd.out_load) begin
            if (i_cmd.out_err) begin
                r_out              <= '0;
                r_out.status       <= i_cmd.err_status;
                r_out.last_of_quad <= 1'b1;
            end else begin
                r_out.vertex_x <= (vx > 34'sd2147483647) ? 32'sh7FFFFFFF :
                                  (vx < -34'sd2147483648) ? 32'sh80000000 : vx[31:0];
                r_out.vertex_y <= (vy > 34'sd2147483647) ? 32'sh7FFFFFFF :
                                  (vy < -34'sd2147483648) ? 32'sh80000000 : vy[31:0];
                r_out.tex_u        <= !cxn;
                r_out.tex_v        <= !cyn;
                r_out.slot_index   <= 5'(r_slot);
                r_out.vertex_index <= {qc13[8:0], i_cmd.corner};
                r_out.status       <= sqv_pkg::ST_OK;
                r_out.last_of_quad <= (i_cmd.corner == 2'd3);
            end
        end
    end

    assign o_out_word = r_out;

    a_qc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qc <= QW'(MAX_QUADS))
        else $error("quad count beyond batch size");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= SW'(TEXTURE_SLOTS))
        else $error("slot count beyond table size");

    a_alloc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> !o_status.slots_full)
        else $error("slot allocated in a full table");
endmodule

// File: rtl/sprite_quad_vertex_setup.sv
// Top level of the sprite quad vertex setup block.
//
// Input channel: one sprite command word per handshake (i_in_valid, o_in_stall).
// Begin-scene clears the batch quad counter and gives no output word; an
// unknown command is dropped. Plain and textured draws give four vertex words
// in corner order, the fourth flagged last_of_quad. A draw into a full batch,
// or a textured draw that misses in a full slot table, gives one error word.
// Output channel: o_out_valid, i_out_stall, one vertex word per handshake.
//
// A draw is accepted, then works out sine and cosine on the shared 33x33
// multiplier, then the scaled products, then each vertex in turn; a textured
// draw first compares the slot table RAM slot by slot, plus one more read on
// a miss. One item is worked on at a time; the next word is taken as soon as
// the last result sits in the output register.
// When the receiver stalls, the output word holds and the datapath waits.
// Reset (synchronous, active low) clears the quad counter and the slot count;
// slot table contents stay undefined until allocated.
module sprite_quad_vertex_setup #(
    parameter int MAX_QUADS     = sqv_pkg::MAX_QUADS_DEF,
    parameter int TEXTURE_SLOTS = sqv_pkg::TEXTURE_SLOTS_DEF,
    parameter int ANGLE_BITS    = sqv_pkg::ANGLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sqv_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sqv_pkg::t_out_word o_out_word
);
    sqv_pkg::t_dp_cmd    cmd;
    sqv_pkg::t_dp_status status;

    // Sequence the scan, the polynomial and the four corners.
    sqv_ctrl #(.TEXTURE_SLOTS(TEXTURE_SLOTS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in_word.command),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Hold item, slot table and arithmetic.
    sqv_datapath #(
        .MAX_QUADS     (MAX_QUADS),
        .TEXTURE_SLOTS (TEXTURE_SLOTS),
        .ANGLE_BITS    (ANGLE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_out_word (o_out_word)
    );
endmodule

// File: tb/sprite_quad_vertex_setup_tb.sv
// Self-checking testbench for the sprite quad vertex setup block.
`timescale 1ns / 1ps

// Predicts vertex words from sprite commands and matches them against the output stream.
class quad_vertex_board;
    sqv_pkg::t_out_word vertex_q[$];
    logic [9:0]  quads_in_batch;
    logic [15:0] slot_tex[sqv_pkg::TEXTURE_SLOTS_DEF];
    int          slot_count;
    int          errors;
    int          words_seen;
    int          err_words;

    function new();
        quads_in_batch = '0;
        slot_count     = 0;
        errors         = 0;
        words_seen     = 0;
        err_words      = 0;
    endfunction

    // Q16 sine of an angle in 1/4096 turn, odd polynomial per quarter turn.
    function longint sine_q16(logic [11:0] a);
        logic [1:0]       quad;
        longint unsigned  rem, x, x2, t, v;
        quad = a[11:10];
        rem  = a[9:0];
        if (quad[0])
            rem = 1024 - rem;
        x  = rem << 20;
        x2 = (x * x) >> 30;
        t  = sqv_pkg::SIN_C9;
        t  = sqv_pkg::SIN_C7 - ((x2 * t) >> 30);
        t  = sqv_pkg::SIN_C5 - ((x2 * t) >> 30);
        t  = sqv_pkg::SIN_C3 - ((x2 * t) >> 30);
        t  = sqv_pkg::SIN_C1 - ((x2 * t) >> 30);
        v  = (x * t) >> 30;
        v  = (v + 8192) >> 14;
        if (v > 65536)
            v = 65536;
        return quad[1] ? -longint'(v) : longint'(v);
    endfunction

    function logic [31:0] place(longint ctr, longint prod);
        longint r;
        r = ctr + ((prod + 65536) >>> 17);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function sqv_pkg::t_out_word error_word(logic [1:0] code);
        sqv_pkg::t_out_word e;
        e = '0;
        e.status       = code;
        e.last_of_quad = 1'b1;
        return e;
    endfunction

    // Note an accepted command word and queue the vertex words it causes.
    function void note_command(sqv_pkg::t_in_word w);
        int                 slot;
        bit                 hit;
        logic [11:0]        ang;
        bit                 flip;
        longint             s, c, hx, hy;
        sqv_pkg::t_out_word o;
        slot = 0;
        hit  = 0;
        ang  = '0;
        flip = 0;
        if (w.command == sqv_pkg::CMD_BEGIN) begin
            quads_in_batch = '0;
            return;
        end
        if (w.command != sqv_pkg::CMD_PLAIN && w.command != sqv_pkg::CMD_TEXTURED)
            return;
        if (quads_in_batch >= sqv_pkg::MAX_QUADS_DEF) begin
            vertex_q.push_back(error_word(sqv_pkg::ST_BATCH_FULL));
            return;
        end
        if (w.command == sqv_pkg::CMD_TEXTURED) begin
            for (int i = 0; i < slot_count; i++) begin
                if (!hit && slot_tex[i] == w.texture_id) begin
                    slot = i;
                    hit  = 1;
                end
            end
            if (!hit) begin
                if (slot_count >= sqv_pkg::TEXTURE_SLOTS_DEF) begin
                    vertex_q.push_back(error_word(sqv_pkg::ST_SLOTS_FULL));
                    return;
                end
                slot = slot_count;
                slot_tex[slot] = w.texture_id;
                slot_count++;
            end
            ang  = w.angle;
            flip = w.flip_x;
        end
        s = sine_q16(ang);
        c = sine_q16(ang + 12'd1024);
        for (int k = 0; k < 4; k++) begin
            // corner order: (-,-) (+,-) (+,+) (-,+)
            hx = (k == 1 || k == 2) ? longint'(w.size_x) : -longint'(w.size_x);
            hy = (k >= 2) ? longint'(w.size_y) : -longint'(w.size_y);
            if (flip)
                hx = -hx;
            o = '0;
            o.vertex_x     = place(longint'(w.center_x), c * hx - s * hy);
            o.vertex_y     = place(longint'(w.center_y), s * hx + c * hy);
            o.tex_u        = (k == 1 || k == 2);
            o.tex_v        = (k >= 2);
            o.slot_index   = slot[4:0];
            o.vertex_index = 11'({quads_in_batch, 2'(k)});
            o.last_of_quad = (k == 3);
            vertex_q.push_back(o);
        end
        quads_in_batch++;
    endfunction

    function void report(string fld, longint e, longint a);
        $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                 $time, fld, e, e, a, a);
        errors++;
    endfunction

    // Check one accepted output word against the oldest expectation.
    function void check_vertex(sqv_pkg::t_out_word got);
        sqv_pkg::t_out_word e;
        words_seen++;
        if (vertex_q.size() == 0) begin
            $display("%0t: unexpected output word, expected none, actual %p", $time, got);
            errors++;
            return;
        end
        e = vertex_q.pop_front();
        if (e.status != sqv_pkg::ST_OK)
            err_words++;
        if (got.vertex_x !== e.vertex_x)         report("vertex_x", e.vertex_x, got.vertex_x);
        if (got.vertex_y !== e.vertex_y)         report("vertex_y", e.vertex_y, got.vertex_y);
        if (got.tex_u !== e.tex_u)               report("tex_u", e.tex_u, got.tex_u);
        if (got.tex_v !== e.tex_v)               report("tex_v", e.tex_v, got.tex_v);
        if (got.slot_index !== e.slot_index)     report("slot_index", e.slot_index, got.slot_index);
        if (got.vertex_index !== e.vertex_index)
            report("vertex_index", e.vertex_index, got.vertex_index);
        if (got.status !== e.status)             report("status", e.status, got.status);
        if (got.last_of_quad !== e.last_of_quad)
            report("last_of_quad", e.last_of_quad, got.last_of_quad);
    endfunction
endclass

module sprite_quad_vertex_setup_tb;
    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    sqv_pkg::t_in_word  i_in_word;
    logic               o_out_valid;
    logic               i_out_stall;
    sqv_pkg::t_out_word o_out_word;

    quad_vertex_board board = new();

    // Percent of cycles the sender idles and the receiver stalls.
    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;

    sprite_quad_vertex_setup dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #40ms;
        $display("sprite_quad_vertex_setup regression: fail");
        $finish;
    end

    // Receiver: stall at random, check every word taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_vertex(o_out_word);
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Offer one command word; hold it until the block takes it.
    task automatic send_word(sqv_pkg::t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk iff (i_in_valid && !o_in_stall));
        board.note_command(w);
        words_sent++;
    endtask

    task automatic send_cmd(logic [1:0] cmd, logic [31:0] cx, logic [31:0] cy,
                            logic [31:0] sx, logic [31:0] sy, logic [11:0] ang,
                            logic flip, logic [15:0] tex);
        sqv_pkg::t_in_word w;
        w.command    = cmd;
        w.center_x   = cx;
        w.center_y   = cy;
        w.size_x     = sx;
        w.size_y     = sy;
        w.angle      = ang;
        w.flip_x     = flip;
        w.texture_id = tex;
        send_word(w);
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(32'h00FF_FFFF);
            2:       return -$urandom_range(32'h00FF_FFFF);
            default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'h0000}
                            + $urandom_range(32'h0010_0000);
        endcase
    endfunction

    // Mostly draws with a small texture pool so hits, misses and a full table all occur.
    task automatic send_random();
        logic [1:0] cmd;
        int         r;
        r = $urandom_range(99);
        if (r < 4)
            cmd = sqv_pkg::CMD_BEGIN;
        else if (r < 7)
            cmd = sqv_pkg::CMD_RESERVED;
        else if (r < 40)
            cmd = sqv_pkg::CMD_PLAIN;
        else
            cmd = sqv_pkg::CMD_TEXTURED;
        send_cmd(cmd, rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                 12'($urandom), 1'($urandom),
                 16'($urandom_range(1) ? $urandom_range(47) : $urandom));
    endtask

    task automatic drain();
        while (board.vertex_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_word      = '0;
        i_out_stall    = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        words_sent     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every command, flip, quarter-turn angles.
        send_cmd(sqv_pkg::CMD_BEGIN, '0, '0, '0, '0, '0, 1'b0, '0);
        send_cmd(sqv_pkg::CMD_PLAIN, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
                 32'h0002_0000, 12'hFFF, 1'b1, 16'hFFFF);
        send_cmd(sqv_pkg::CMD_PLAIN, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, '0, 1'b0, '0);
        send_cmd(sqv_pkg::CMD_PLAIN, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, '0, 1'b0, '0);
        send_cmd(sqv_pkg::CMD_PLAIN, '0, '0, '0, '0, '0, 1'b0, '0);
        send_cmd(sqv_pkg::CMD_PLAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, '0, 1'b0, '0);
        send_cmd(sqv_pkg::CMD_TEXTURED, '0, '0, 32'h0001_0000, 32'h0001_0000,
                 12'd0, 1'b0, 16'h0000);
        send_cmd(sqv_pkg::CMD_TEXTURED, '0, '0, 32'h0001_0000, 32'h0001_0000,
                 12'd1024, 1'b0, 16'hFFFF);
        send_cmd(sqv_pkg::CMD_TEXTURED, '0, '0, 32'h0001_0000, 32'h0001_0000,
                 12'd2048, 1'b1, 16'h0000);
        send_cmd(sqv_pkg::CMD_TEXTURED, '0, '0, 32'h0001_0000, 32'h0001_0000,
                 12'd3072, 1'b1, 16'hFFFF);
        send_cmd(sqv_pkg::CMD_TEXTURED, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF, 12'd4095, 1'b1, 16'h1234);
        send_cmd(sqv_pkg::CMD_TEXTURED, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 12'd512, 1'b0, 16'h1234);
        send_cmd(sqv_pkg::CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 12'hFFF, 1'b1, 16'hFFFF);
        send_cmd(sqv_pkg::CMD_BEGIN, 32'hFFFF_FFFF, '0, '0, '0, '0, 1'b0, '0);
        send_cmd(sqv_pkg::CMD_PLAIN, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001,
                 32'hFFFF_FFFF, '0, 1'b0, '0);

        // Random traffic under each idling mix.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 37 : 72) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 37 : 72) : 0;
            if (ph == 1)
                recv_stall_pct = 0;
            for (int n = 0; n < 68; n++)
                send_random();
        end

        // Push the slot table past full with fresh ids, then hit an old one.
        send_idle_pct  = 0;
        recv_stall_pct = 10;
        for (int n = 0; n < 34; n++)
            send_cmd(sqv_pkg::CMD_TEXTURED, rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                     12'($urandom), 1'($urandom), 16'(32'hC000 + n));
        send_cmd(sqv_pkg::CMD_TEXTURED, '0, '0, 32'h0002_0000, 32'h0002_0000,
                 12'd300, 1'b0, 16'h0000);

        i_in_valid <= 1'b0;
        drain();

        $display("Run covered %0d command words and %0d vertex words (%0d error words),",
                 words_sent, board.words_seen, board.err_words);
        $display("with a full slot table, every command and four idling mixes.");
        if (board.errors == 0 && board.vertex_q.size() == 0) begin
            $display("sprite_quad_vertex_setup regression: pass");
        end else begin
            $display("sprite_quad_vertex_setup regression: fail");
        end
        $finish;
    end
endmodule
